// ===== sv/crf_pkg.sv =====
package crf_pkg;

  localparam int MAX_CYCLE_DEF = 64;
  localparam int SENS_W        = 16;
  localparam int CLEN_W        = 7;
  localparam int SAMPLE_W      = 16;
  localparam int QUOT_W        = 17;
  localparam int OUT_W         = 6;
  localparam int LEN_W         = 25;
  localparam logic [LEN_W-1:0] LEN_CAP = 25'h100_0000;
  localparam int CFG_IDX_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SENS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEN = 8'd1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RUN,
    CMD_MERGE,
    CMD_INIT_RD,
    CMD_INIT_CMP,
    CMD_PASS_SETUP,
    CMD_RD_CUR,
    CMD_RD_NXT,
    CMD_STEP,
    CMD_RANK,
    CMD_PASS_END,
    CMD_OUT_RD,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_sample;
    logic init_more;
    logic pass_more;
    logic pass_done;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/canonical_rotation_finder_core.sv =====
// Canonical rotation finder. Samples of one cycle arrive one per beat; each is
// divided by sensitivity (truncating toward zero) in a serial divider, and no new
// sample is accepted until that one is coded into the runs. On the last sample of
// a cycle the runs are merged across the wrap, the candidate starts are built by
// a read and a compare per run, and each reduction pass reads, steps and ranks
// each candidate visited (single-port reads of the candidate and run stores);
// passes continue until one candidate is left or 4*MAX_CYCLE passes have run.
// One result beat then carries the sample index where the canonical rotation
// starts. A finished result waits in an output register while the next cycle
// loads. Configuration writes are always ready.
module canonical_rotation_finder_core #(
  parameter int MAX_CYCLE = crf_pkg::MAX_CYCLE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [crf_pkg::SAMPLE_W-1:0]   in_tdata,   // [15:0] sample
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [5:0] rotation_start, [7:6] zero
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crf_pkg::SENS_W-1:0]     cfg_data
);
  import crf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  crf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  crf_datapath #(.MAX_CYCLE(MAX_CYCLE)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sv/crf_div.sv =====
module crf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [crf_pkg::SAMPLE_W-1:0]  dividend,
  input  logic [crf_pkg::SENS_W-1:0]    divisor,
  output logic                          done,
  output logic [crf_pkg::QUOT_W-1:0]    quot
);
  import crf_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [QUOT_W-1:0] mag_r, mag_nxt;
  logic [QUOT_W-1:0] rem_r, rem_nxt;
  logic [QUOT_W-1:0] quo_r, quo_nxt;
  logic [SENS_W-1:0] dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;
  logic [QUOT_W-1:0] rem_sh;
  logic [QUOT_W-1:0] dvd_ext;

  // restoring division on the magnitude, one quotient bit a cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    dvd_ext  = {dividend[SAMPLE_W-1], dividend};
    rem_sh   = {rem_r[QUOT_W-2:0], mag_r[QUOT_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      mag_nxt  = dividend[SAMPLE_W-1] ? (~dvd_ext + 1'b1) : dvd_ext;
      rem_nxt  = '0;
      quo_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[SAMPLE_W-1];
    end else if (busy_r) begin
      mag_nxt = {mag_r[QUOT_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[QUOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[QUOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(QUOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quot = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ===== sv/crf_datapath.sv =====
module crf_datapath #(
  parameter int MAX_CYCLE = crf_pkg::MAX_CYCLE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  crf_pkg::cmd_t                  cmd,
  output crf_pkg::stat_t                 stat,
  input  logic [crf_pkg::SAMPLE_W-1:0]   in_tdata,
  input  logic                           cfg_valid,
  input  logic [crf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crf_pkg::SENS_W-1:0]     cfg_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata
);
  import crf_pkg::*;

  localparam int AW = (MAX_CYCLE > 1) ? $clog2(MAX_CYCLE) : 1;
  localparam int CW = $clog2(MAX_CYCLE + 1);
  localparam int NW = (CW > CLEN_W) ? CW : CLEN_W;
  localparam int UW = CW + 1;
  localparam int MAX_PASSES = 4 * MAX_CYCLE;
  localparam int PW = $clog2(MAX_PASSES + 1);

  // configuration
  logic [SENS_W-1:0] sens_r;
  logic [CLEN_W-1:0] clen_r;

  // run tracking
  logic [CW-1:0]            cnt_r, rtot_r;
  logic [CW-1:0]            r0_idx_r, r0_cnt_r, rl_idx_r, rl_cnt_r;
  logic signed [QUOT_W-1:0] r0_val_r, rl_val_r;

  // run memory
  logic [CW-1:0]            run_idx_m [MAX_CYCLE];
  logic signed [QUOT_W-1:0] run_val_m [MAX_CYCLE];
  logic [CW-1:0]            run_cnt_m [MAX_CYCLE];
  logic [CW-1:0]            rd_idx_r, rd_cnt_r;
  logic signed [QUOT_W-1:0] rd_val_r;

  // candidate memory
  logic [AW-1:0]    cm_start_m [MAX_CYCLE];
  logic [AW-1:0]    cm_end_m   [MAX_CYCLE];
  logic [LEN_W-1:0] cm_len_m   [MAX_CYCLE];
  logic [AW-1:0]    cr_start_r, cr_end_r;
  logic [LEN_W-1:0] cr_len_r;

  // best candidate and working candidate
  logic [AW-1:0]            c0_start_r, c0_end_r, w_start_r, w_end_r;
  logic [LEN_W-1:0]         c0_len_r, w_len_r;
  logic signed [QUOT_W-1:0] c0_lval_r;
  logic [CW-1:0]            c0_lcnt_r;
  logic                     adv2_r;

  logic [CW-1:0] ictr_r, ctot_r;
  logic [UW-1:0] cur_r, kept_r;
  logic [PW-1:0] passes_r;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  // divider
  logic              div_done;
  logic [QUOT_W-1:0] q_raw;
  logic signed [QUOT_W-1:0] q;
  logic [SENS_W-1:0] sens_eff;

  assign sens_eff = (sens_r == '0) ? SENS_W'(1) : sens_r;
  assign q = signed'(q_raw);

  crf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd == CMD_LOAD),
    .dividend (in_tdata),
    .divisor  (sens_eff),
    .done     (div_done),
    .quot     (q_raw)
  );

  logic [NW-1:0] n_eff, clen_ext;
  logic          merge_hit;
  logic [CW-1:0] d_after;

  logic                     run_we;
  logic [AW-1:0]            run_wa, run_ra;
  logic [CW-1:0]            run_wi, run_wc;
  logic signed [QUOT_W-1:0] run_wv;
  logic                     cw_en;
  logic [AW-1:0]            cw_addr, cw_start, cw_end, cr_addr;
  logic [LEN_W-1:0]         cw_len;

  logic [UW-1:0]    nxt_u;
  logic             nxt_is0;
  logic [AW-1:0]    n_start, n_end, g_end;
  logic [LEN_W-1:0] n_len, g_len, g_by;
  logic [LEN_W:0]   g_sum;
  logic             g_abs;

  logic rd_gt, rd_eq, w_gt, w_eq;

  function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] x, input logic [CW-1:0] d);
    logic [CW:0] s;
    s = {1'b0, CW'(x)} + 1'b1;
    return (s == {1'b0, d}) ? '0 : AW'(s);
  endfunction

  function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] x, input logic [CW-1:0] d);
    return (x == '0) ? AW'(d - 1'b1) : x - 1'b1;
  endfunction

  assign clen_ext = NW'(clen_r);
  assign n_eff = (clen_r == '0) ? NW'(1) :
                 ((clen_ext > NW'(MAX_CYCLE)) ? NW'(MAX_CYCLE) : clen_ext);
  assign merge_hit = (rtot_r > CW'(1)) && (r0_val_r == rl_val_r);
  assign d_after = merge_hit ? rtot_r - 1'b1 : rtot_r;

  // next candidate of the pass and the grow step
  assign nxt_u   = (cur_r + 1'b1 == UW'(ctot_r)) ? '0 : cur_r + 1'b1;
  assign nxt_is0 = (nxt_u == '0);
  assign n_start = nxt_is0 ? c0_start_r : cr_start_r;
  assign n_end   = nxt_is0 ? c0_end_r   : cr_end_r;
  assign n_len   = nxt_is0 ? c0_len_r   : cr_len_r;
  assign g_abs   = (w_end_r == n_start);
  assign g_by    = g_abs ? n_len : LEN_W'(1);
  assign g_sum   = {1'b0, w_len_r} + {1'b0, g_by};
  assign g_len   = (g_sum > {1'b0, LEN_CAP}) ? LEN_CAP : g_sum[LEN_W-1:0];
  assign g_end   = g_abs ? n_end : inc_wrap(w_end_r, rtot_r);

  // ranking: value then count, candidates by length first
  assign rd_gt = (rd_val_r > r0_val_r) || ((rd_val_r == r0_val_r) && (rd_cnt_r > r0_cnt_r));
  assign rd_eq = (rd_val_r == r0_val_r) && (rd_cnt_r == r0_cnt_r);
  assign w_gt  = (w_len_r > c0_len_r) || ((w_len_r == c0_len_r) &&
                 ((rd_val_r > c0_lval_r) ||
                  ((rd_val_r == c0_lval_r) && (rd_cnt_r > c0_lcnt_r))));
  assign w_eq  = (w_len_r == c0_len_r) && (rd_val_r == c0_lval_r) &&
                 (rd_cnt_r == c0_lcnt_r);

  // memory addresses and write data
  always_comb begin
    run_we   = 1'b0;
    run_wa   = '0;
    run_wi   = cnt_r;
    run_wv   = q;
    run_wc   = CW'(1);
    run_ra   = '0;
    cw_en    = 1'b0;
    cw_addr  = AW'(ictr_r);
    cw_start = AW'(ictr_r);
    cw_end   = inc_wrap(AW'(ictr_r), rtot_r);
    cw_len   = LEN_W'(1);
    cr_addr  = AW'(cur_r);
    case (cmd)
      CMD_RUN: begin
        run_we = 1'b1;
        if (cnt_r == '0) begin
          run_wa = '0;
          run_wi = '0;
        end else if (rl_val_r == q) begin
          run_wa = AW'(rtot_r - 1'b1);
          run_wi = rl_idx_r;
          run_wc = rl_cnt_r + 1'b1;
        end else begin
          run_wa = AW'(rtot_r);
        end
      end
      CMD_MERGE: begin
        run_we = merge_hit;
        run_wa = '0;
        run_wi = r0_idx_r + rl_idx_r;
        run_wv = r0_val_r;
        run_wc = r0_cnt_r + rl_cnt_r;
      end
      CMD_INIT_RD:  run_ra = AW'(ictr_r);
      CMD_INIT_CMP: begin
        cw_en   = rd_eq;
        cw_addr = AW'(ctot_r);
      end
      CMD_RD_CUR: cr_addr = AW'(cur_r);
      CMD_RD_NXT: cr_addr = AW'(nxt_u);
      CMD_STEP:   run_ra  = dec_wrap(g_end, rtot_r);
      CMD_RANK: begin
        cw_en    = (cur_r != '0) && !w_gt && w_eq;
        cw_addr  = AW'(kept_r);
        cw_start = w_start_r;
        cw_end   = w_end_r;
        cw_len   = w_len_r;
      end
      CMD_OUT_RD: run_ra = c0_start_r;
      default: ;
    endcase
  end

  // run store
  always_ff @(posedge clk) begin
    if (run_we) begin
      run_idx_m[run_wa] <= run_wi;
      run_val_m[run_wa] <= run_wv;
      run_cnt_m[run_wa] <= run_wc;
    end
    rd_idx_r <= run_idx_m[run_ra];
    rd_val_r <= run_val_m[run_ra];
    rd_cnt_r <= run_cnt_m[run_ra];
  end

  // candidate store
  always_ff @(posedge clk) begin
    if (cw_en) begin
      cm_start_m[cw_addr] <= cw_start;
      cm_end_m[cw_addr]   <= cw_end;
      cm_len_m[cw_addr]   <= cw_len;
    end
    cr_start_r <= cm_start_m[cr_addr];
    cr_end_r   <= cm_end_m[cr_addr];
    cr_len_r   <= cm_len_m[cr_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r      <= SENS_W'(1);
      clen_r      <= CLEN_W'(64);
      cnt_r       <= '0;
      rtot_r      <= '0;
      ctot_r      <= '0;
      ictr_r      <= '0;
      cur_r       <= '0;
      kept_r      <= '0;
      passes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_SENS) sens_r <= cfg_data;
        else if (cfg_index == REG_CLEN) clen_r <= cfg_data[CLEN_W-1:0];
      end
      case (cmd)
        CMD_RUN: begin
          if (cnt_r == '0) rtot_r <= CW'(1);
          else if (rl_val_r != q) rtot_r <= rtot_r + 1'b1;
          cnt_r <= stat.last_sample ? '0 : cnt_r + 1'b1;
        end
        CMD_MERGE: begin
          rtot_r <= d_after;
          ctot_r <= CW'(1);
          ictr_r <= CW'(1);
        end
        CMD_INIT_CMP: begin
          if (!rd_gt && rd_eq) ctot_r <= ctot_r + 1'b1;
          ictr_r <= ictr_r + 1'b1;
        end
        CMD_PASS_SETUP: begin
          cur_r    <= '0;
          kept_r   <= '0;
          passes_r <= passes_r + 1'b1;
        end
        CMD_RANK: begin
          if (cur_r == '0 || w_gt) kept_r <= UW'(1);
          else if (w_eq) kept_r <= kept_r + 1'b1;
          cur_r <= cur_r + (adv2_r ? UW'(2) : UW'(1));
        end
        CMD_PASS_END: ctot_r <= CW'(kept_r);
        CMD_OUT_RD:   passes_r <= '0;
        default: ;
      endcase
      if (cmd == CMD_OUT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_RUN: begin
        if (cnt_r == '0) begin
          r0_idx_r <= '0;
          r0_val_r <= q;
          r0_cnt_r <= CW'(1);
          rl_idx_r <= '0;
          rl_val_r <= q;
          rl_cnt_r <= CW'(1);
        end else if (rl_val_r == q) begin
          rl_cnt_r <= rl_cnt_r + 1'b1;
          if (rtot_r == CW'(1)) r0_cnt_r <= r0_cnt_r + 1'b1;
        end else begin
          rl_idx_r <= cnt_r;
          rl_val_r <= q;
          rl_cnt_r <= CW'(1);
        end
      end
      CMD_MERGE: begin
        if (merge_hit) begin
          r0_idx_r <= r0_idx_r + rl_idx_r;
          r0_cnt_r <= r0_cnt_r + rl_cnt_r;
        end
        c0_start_r <= '0;
        c0_end_r   <= (d_after == CW'(1)) ? '0 : AW'(1);
        c0_len_r   <= LEN_W'(1);
        c0_lval_r  <= r0_val_r;
        c0_lcnt_r  <= merge_hit ? r0_cnt_r + rl_cnt_r : r0_cnt_r;
      end
      CMD_INIT_CMP: begin
        if (rd_gt) begin
          c0_start_r <= AW'(ictr_r);
          c0_end_r   <= inc_wrap(AW'(ictr_r), rtot_r);
          c0_len_r   <= LEN_W'(1);
          c0_lval_r  <= rd_val_r;
          c0_lcnt_r  <= rd_cnt_r;
        end
      end
      CMD_RD_NXT: begin
        if (cur_r == '0) begin
          w_start_r <= c0_start_r;
          w_end_r   <= c0_end_r;
          w_len_r   <= c0_len_r;
        end else begin
          w_start_r <= cr_start_r;
          w_end_r   <= cr_end_r;
          w_len_r   <= cr_len_r;
        end
      end
      CMD_STEP: begin
        w_len_r <= g_len;
        w_end_r <= g_end;
        adv2_r  <= g_abs;
      end
      CMD_RANK: begin
        if (cur_r == '0 || w_gt) begin
          c0_start_r <= w_start_r;
          c0_end_r   <= w_end_r;
          c0_len_r   <= w_len_r;
          c0_lval_r  <= rd_val_r;
          c0_lcnt_r  <= rd_cnt_r;
        end
      end
      CMD_OUT: out_data_r <= OUT_W'(rd_idx_r);
      default: ;
    endcase
  end

  assign stat.div_done    = div_done;
  assign stat.last_sample = (NW'(cnt_r) + 1'b1) >= n_eff;
  assign stat.init_more   = ictr_r < rtot_r;
  assign stat.pass_more   = (ctot_r > CW'(1)) && (passes_r < PW'(MAX_PASSES));
  assign stat.pass_done   = cur_r >= UW'(ctot_r);
  assign stat.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - OUT_W){1'b0}}, out_data_r};

  a_rtot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rtot_r <= CW'(MAX_CYCLE))
    else $error("run total above store depth");
  a_kept_le_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_RANK) |-> (kept_r <= cur_r))
    else $error("kept candidate index passed the scan index");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_OUT) |-> (!out_valid_r || out_tready))
    else $error("result overwritten before it was taken");
  a_ctot_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_PASS_SETUP) |-> (ctot_r > CW'(1)))
    else $error("reduction pass started with a single candidate");

endmodule

// ===== sv/crf_ctrl.sv =====
module crf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  crf_pkg::stat_t  stat,
  output crf_pkg::cmd_t   cmd
);
  import crf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_RUN, S_MERGE, S_ICHK, S_IRD, S_ICMP, S_PCHK,
    S_PSET, S_RDC, S_RDN, S_STEP, S_RANK, S_PEND, S_ORD, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // sequence the load, run coding, candidate setup and reduction passes
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_IDLE: if (in_tvalid) begin
        cmd       = CMD_LOAD;
        state_nxt = S_DIV;
      end
      S_DIV:  if (stat.div_done) state_nxt = S_RUN;
      S_RUN: begin
        cmd       = CMD_RUN;
        state_nxt = stat.last_sample ? S_MERGE : S_IDLE;
      end
      S_MERGE: begin
        cmd       = CMD_MERGE;
        state_nxt = S_ICHK;
      end
      S_ICHK: state_nxt = stat.init_more ? S_IRD : S_PCHK;
      S_IRD: begin
        cmd       = CMD_INIT_RD;
        state_nxt = S_ICMP;
      end
      S_ICMP: begin
        cmd       = CMD_INIT_CMP;
        state_nxt = S_ICHK;
      end
      S_PCHK: state_nxt = stat.pass_more ? S_PSET : S_ORD;
      S_PSET: begin
        cmd       = CMD_PASS_SETUP;
        state_nxt = S_RDC;
      end
      S_RDC: begin
        cmd       = CMD_RD_CUR;
        state_nxt = S_RDN;
      end
      S_RDN: begin
        cmd       = CMD_RD_NXT;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd       = CMD_STEP;
        state_nxt = S_RANK;
      end
      S_RANK: begin
        cmd       = CMD_RANK;
        state_nxt = S_PEND;
      end
      S_PEND: if (stat.pass_done) begin
        cmd       = CMD_PASS_END;
        state_nxt = S_PCHK;
      end else begin
        state_nxt = S_RDC;
      end
      S_ORD: begin
        cmd       = CMD_OUT_RD;
        state_nxt = S_OUT;
      end
      // hold the start-index read while the previous result is still waiting
      S_OUT: if (stat.out_free) begin
        cmd       = CMD_OUT;
        state_nxt = S_IDLE;
      end else begin
        cmd       = CMD_OUT_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

// ===== test/crf_checker.sv =====
`timescale 1ns / 100ps

// Watches all three channels, tracks the rotation finder's state and checks
// every result beat against the predicted rotation start.
module crf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);
  import crf_pkg::*;

  localparam int NMAX = 64;
  localparam int PASS_LIMIT = 4 * NMAX;
  localparam int CAP = 32'h0100_0000;

  logic [15:0] sens_reg;
  logic [6:0]  clen_reg;
  int          taken;
  int          run_start [NMAX];
  int          run_q     [NMAX];
  int          run_cnt   [NMAX];
  int          runs;
  int          cand_first[NMAX];
  int          cand_len  [NMAX];
  int          cands;
  logic [5:0]  rotation_q[$];

  function automatic int cmp_runs(int a, int b);
    if (run_q[a] != run_q[b]) return run_q[a] < run_q[b] ? -1 : 1;
    if (run_cnt[a] != run_cnt[b]) return run_cnt[a] < run_cnt[b] ? -1 : 1;
    return 0;
  endfunction

  function automatic int cmp_cands(int a, int b, int d);
    if (cand_len[a] != cand_len[b]) return cand_len[a] < cand_len[b] ? -1 : 1;
    return cmp_runs((cand_first[a] + cand_len[a] - 1) % d,
                    (cand_first[b] + cand_len[b] - 1) % d);
  endfunction

  function automatic int add_len(int l, int by);
    return (l + by > CAP) ? CAP : l + by;
  endfunction

  // Merge across the wrap, pick initial candidates, reduce to one.
  function automatic logic [5:0] find_rotation();
    int d, c, passes, cur, kept, nrun, nxt, adv;
    passes = 0;
    if (runs > 1 && run_q[0] == run_q[runs-1]) begin
      run_start[0] += run_start[runs-1];
      run_cnt[0] += run_cnt[runs-1];
      runs--;
    end
    d = runs;
    cand_first[0] = 0;
    cand_len[0] = 1;
    cands = 1;
    for (int i = 1; i < d; i++) begin
      c = cmp_runs(0, i);
      if (c < 0) begin
        cand_first[0] = i;
        cand_len[0] = 1;
      end else if (c == 0) begin
        cand_first[cands] = i;
        cand_len[cands] = 1;
        cands++;
      end
    end
    while (cands > 1 && passes < PASS_LIMIT) begin
      passes++;
      cur = 0;
      kept = 0;
      while (cur < cands) begin
        nrun = (cand_first[cur] + cand_len[cur]) % d;
        nxt = (cur + 1) % cands;
        if (nrun == cand_first[nxt]) begin
          cand_len[cur] = add_len(cand_len[cur], cand_len[nxt]);
          adv = 2;
        end else begin
          cand_len[cur] = add_len(cand_len[cur], 1);
          adv = 1;
        end
        if (cur == 0) begin
          kept++;
        end else begin
          c = cmp_cands(0, cur, d);
          if (c < 0) begin
            cand_first[0] = cand_first[cur];
            cand_len[0] = cand_len[cur];
            kept = 1;
          end else if (c == 0) begin
            cand_first[kept] = cand_first[cur];
            cand_len[kept] = cand_len[cur];
            kept++;
          end
        end
        cur += adv;
      end
      cands = kept;
    end
    return run_start[cand_first[0] % d][5:0];
  endfunction

  // Fold one sample into the runs; queue a rotation at the end of a cycle.
  function automatic void take_sample(logic signed [15:0] s);
    int q, div, n;
    div = (sens_reg == 0) ? 1 : int'(sens_reg);
    n = (clen_reg == 0) ? 1 : int'(clen_reg);
    if (n > NMAX) n = NMAX;
    q = int'(s) / div;
    if (taken == 0) begin
      run_start[0] = 0;
      run_q[0] = q;
      run_cnt[0] = 1;
      runs = 1;
    end else if (run_q[runs-1] == q) begin
      run_cnt[runs-1]++;
    end else begin
      run_start[runs] = taken;
      run_q[runs] = q;
      run_cnt[runs] = 1;
      runs++;
    end
    taken++;
    if (taken >= n) begin
      rotation_q.push_back(find_rotation());
      taken = 0;
    end
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      sens_reg = 16'd1;
      clen_reg = 7'd64;
      taken = 0;
      runs = 0;
      cands = 0;
      rotation_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SENS) sens_reg = cfg_data;
        else if (cfg_index == REG_CLEN) clen_reg = cfg_data[6:0];
      end
      if (in_tvalid && in_tready) take_sample(in_tdata);
      // compare each result beat with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (rotation_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", out_tdata);
        end else begin
          want = {2'b00, rotation_q.pop_front()};
          if (out_tdata !== want) begin
            errors++;
            if (errors <= 10)
              $display("rotation mismatch: expected %h got %h", want, out_tdata);
          end
        end
      end
    end
    pending = rotation_q.size();
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import crf_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  int          cycles;
  int          burst_left;
  int          stall_mode;
  int          cur_sens;
  int          cur_clen;

  canonical_rotation_finder_core dut (.*);

  crf_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Bound the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver back-pressure: switch between always ready and random stalls.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Write one register once the block has drained.
  task automatic write_reg(logic [7:0] idx, logic [15:0] value);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_SENS) cur_sens = int'(value);
    else cur_clen = int'(value[6:0]);
  endtask

  // Send one sample beat; bursts of random length with random gaps.
  task automatic send_sample(logic [15:0] s);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid = 1'b1;
    in_tdata = s;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
    burst_left--;
  endtask

  // Sample on the grid of the current divider, so runs and ties form.
  function automatic logic [15:0] grid_sample(int q);
    int div, v;
    div = (cur_sens == 0) ? 1 : cur_sens;
    v = q * div;
    if (q > 0 && div > 1) v += $urandom_range(0, div - 1);
    if (q < 0 && div > 1) v -= $urandom_range(0, div - 1);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // One cycle's worth of samples: periodic patterns or plain noise.
  task automatic send_cycle();
    int n, per, qmax, div;
    int pat[8];
    n = (cur_clen == 0) ? 1 : (cur_clen > 64 ? 64 : cur_clen);
    div = (cur_sens == 0) ? 1 : cur_sens;
    qmax = 32767 / div;
    if (qmax > 2) qmax = 2;
    per = $urandom_range(1, 8);
    for (int i = 0; i < 8; i++) pat[i] = $urandom_range(0, 2 * qmax) - qmax;
    if ($urandom_range(0, 9) < 7) begin
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) send_sample(16'($urandom));
        else send_sample(grid_sample(pat[i % per]));
      end
    end else begin
      for (int i = 0; i < n; i++) send_sample(16'($urandom));
    end
  endtask

  initial begin
    int sens_set[10] = '{1, 2, 7, 100, 65535, 3, 1, 0, 1000, 5};
    int clen_set[10] = '{64, 127, 1, 8, 64, 0, 33, 16, 5, 64};
    int sent;
    burst_left = 0;
    cur_sens = 1;
    cur_clen = 64;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SENS;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // extremes of the sample field
    write_reg(REG_CLEN, 16'd4);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    send_sample(16'hffff);
    // zero divider and zero cycle length act as one
    write_reg(REG_SENS, 16'd0);
    write_reg(REG_CLEN, 16'd0);
    send_sample(16'd5);
    send_sample(-16'sd5);
    // truncation toward zero and merge across the wrap
    write_reg(REG_SENS, 16'd3);
    write_reg(REG_CLEN, 16'd6);
    send_sample(16'd7);
    send_sample(-16'sd7);
    send_sample(16'd8);
    send_sample(-16'sd8);
    send_sample(16'd6);
    send_sample(16'd7);
    // fully periodic cycle: reduction runs out of passes
    write_reg(REG_SENS, 16'd1);
    send_sample(16'd1);
    send_sample(16'd2);
    send_sample(16'd1);
    send_sample(16'd2);
    send_sample(16'd1);
    send_sample(16'd2);
    // cycle length lowered in the middle of a cycle
    write_reg(REG_CLEN, 16'd8);
    send_sample(16'd9);
    send_sample(16'd9);
    send_sample(16'd4);
    write_reg(REG_CLEN, 16'd2);
    send_sample(16'd9);

    // random phases over several register settings
    for (int p = 0; p < 10; p++) begin
      write_reg(REG_SENS, 16'(sens_set[p]));
      write_reg(REG_CLEN, 16'(clen_set[p]));
      sent = 0;
      while (sent < 180) begin
        send_cycle();
        sent += (cur_clen == 0) ? 1 : (cur_clen > 64 ? 64 : cur_clen);
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
